// ----- rtl/core/tpbi_pkg.sv -----
// Shared types and constants for the tie-point bilinear interpolator.
// Field widths, register indexes, command and status codes.
// No dependencies.
`timescale 1ns / 1ps

package tpbi_pkg;

  localparam int LINE_W    = 14;
  localparam int ADDR_W    = 14;
  localparam int VAL_W     = 32;
  localparam int LPS_W     = 12;
  localparam int ZONE_W    = 10;
  localparam int TCOL_W    = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  localparam int ROW_W  = LINE_W + 1;
  localparam int BASE_W = ROW_W + TCOL_W;
  localparam int CW     = BASE_W + 1;
  localparam int WGT_W  = 2 * ZONE_W;
  localparam int DEN_W  = 2 * ZONE_W;
  localparam int PROD_W = VAL_W + WGT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int QUO_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_SCAN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ALT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ACT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_COLUMNS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LONGITUDE = 3'd4;

  localparam logic [LPS_W-1:0]  LPS_RST  = 12'd30;
  localparam logic [ZONE_W-1:0] ZALT_RST = 10'd10;
  localparam logic [ZONE_W-1:0] ZACT_RST = 10'd8;
  localparam logic [TCOL_W-1:0] TCOL_RST = 12'd394;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

endpackage

// ----- rtl/core/tpbi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, N stages.
// Remainder seed rem_i must be below div_i. No package dependencies.
`timescale 1ns / 1ps

module tpbi_div #(
  parameter int N = 14,
  parameter int M = 12
) (
  input  logic         clk,
  input  logic         en,
  input  logic [M-1:0] rem_i,
  input  logic [N-1:0] num_i,
  input  logic [M-1:0] div_i,
  output logic [N-1:0] quo_o,
  output logic [M-1:0] rem_o
);

  logic [M-1:0] rem_r   [N];
  logic [N-1:0] num_r   [N];
  logic [M-1:0] rem_nxt [N];
  logic [N-1:0] num_nxt [N];
  logic [M-1:0] pr      [N];
  logic [N-1:0] pn      [N];
  logic [M:0]   trial   [N];
  logic         ge      [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      pr[k]       = (k == 0) ? rem_i : rem_r[(k == 0) ? 0 : k - 1];
      pn[k]       = (k == 0) ? num_i : num_r[(k == 0) ? 0 : k - 1];
      trial[k]    = {pr[k], pn[k][N-1]};
      ge[k]       = trial[k] >= {1'b0, div_i};
      num_nxt[k]  = {pn[k][N-2:0], ge[k]};
      rem_nxt[k]  = ge[k] ? M'(trial[k] - {1'b0, div_i}) : trial[k][M-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
      end
    end
  end

  assign quo_o = num_r[N-1];
  assign rem_o = rem_r[N-1];

endmodule

// ----- rtl/core/tie_point_bilinear_interpolator.sv -----
// Top level: tie-point store in two parity banks plus the interpolation pipeline.
// Depends on tpbi_pkg and tpbi_div.
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_ready   | command, tie write or pixel line/column
//   out_    | out       | out_valid/out_ready | value, status
//   cfg_    | in        | cfg_we              | cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; the path runs through the 14-step
// index dividers, six address/memory/blend stages, the 32-step rounding divider and the output register.
// Four corner reads per cycle, while the pipeline advances, come from two address-parity banks, two read ports each.
// After reset a clearing pass steps through every bank index and zeroes the valid bits;
// in_ready stays low meanwhile.
// The whole pipeline stalls only while a result waits at the output.
`timescale 1ns / 1ps

module tie_point_bilinear_interpolator
  import tpbi_pkg::*;
#(
  parameter int TIE_DEPTH = 16384,
  parameter int FRAC_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [ADDR_W-1:0]       in_tie_address,
  input  logic signed [VAL_W-1:0] in_tie_value,
  input  logic                    in_tie_valid,
  input  logic [LINE_W-1:0]       in_line_index,
  input  logic [LINE_W-1:0]       in_pixel_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic [1:0]              out_status,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int AW = $clog2(TIE_DEPTH);
  localparam int BD = (TIE_DEPTH + 1) / 2;
  localparam int BW = $clog2(BD);
  localparam int WW = (FRAC_BITS + 10 > 34) ? FRAC_BITS + 10 : 34;
  localparam logic [WW-1:0] K180 = WW'(180) << FRAC_BITS;
  localparam logic [WW-1:0] K360 = WW'(360) << FRAC_BITS;
  localparam logic signed [WW-1:0] SAT_HI = WW'(32'sh7FFFFFFF);
  localparam logic signed [WW-1:0] SAT_LO = WW'(32'sh80000000);

  typedef struct packed {
    logic                    vld;
    logic                    cmd;
    logic [ADDR_W-1:0]       waddr;
    logic signed [VAL_W-1:0] wval;
    logic                    wvld;
  } front_t;

  typedef struct packed {
    logic    vld;
    logic    pix;
    status_t status;
    logic    neg;
    logic    pos;
  } back_t;

  // configuration
  logic [LPS_W-1:0]  lps_r;
  logic [ZONE_W-1:0] za_r, zc_r;
  logic [TCOL_W-1:0] tcol_r;
  logic              wrap_r;
  logic [LPS_W-1:0]  lps_eff;
  logic [ZONE_W-1:0] za_eff, zc_eff;
  logic [DEN_W-1:0]  den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lps_r  <= LPS_RST;
      za_r   <= ZALT_RST;
      zc_r   <= ZACT_RST;
      tcol_r <= TCOL_RST;
      wrap_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINES_PER_SCAN: lps_r  <= cfg_data[LPS_W-1:0];
        CFG_ZONE_ALT:       za_r   <= cfg_data[ZONE_W-1:0];
        CFG_ZONE_ACT:       zc_r   <= cfg_data[ZONE_W-1:0];
        CFG_TIE_COLUMNS:    tcol_r <= cfg_data[TCOL_W-1:0];
        CFG_WRAP_LONGITUDE: wrap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lps_eff = (lps_r == '0) ? LPS_W'(1) : lps_r;
  assign za_eff  = (za_r == '0) ? ZONE_W'(1) : za_r;
  assign zc_eff  = (zc_r == '0) ? ZONE_W'(1) : zc_r;

  always_ff @(posedge clk) begin
    den_r <= DEN_W'(za_eff) * DEN_W'(zc_eff);
  end

  // flow control and clearing pass
  logic          adv, acc;
  logic          clr_busy_r;
  logic [BW-1:0] clr_idx_r;
  logic          out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !clr_busy_r;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + BW'(1);
      if (clr_idx_r == BW'(BD - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // index dividers
  logic [LINE_W-1:0] scan_q, row_q, col_q;
  logic [LPS_W-1:0]  scan_rem;
  logic [ZONE_W-1:0] row_rem, col_rem;
  front_t            fr_r [LINE_W];

  tpbi_div #(.N(LINE_W), .M(LPS_W)) u_div_scan (
    .clk(clk), .en(adv), .rem_i('0), .num_i(in_line_index), .div_i(lps_eff),
    .quo_o(scan_q), .rem_o(scan_rem)
  );

  tpbi_div #(.N(LINE_W), .M(ZONE_W)) u_div_row (
    .clk(clk), .en(adv), .rem_i('0), .num_i(in_line_index), .div_i(za_eff),
    .quo_o(row_q), .rem_o(row_rem)
  );

  tpbi_div #(.N(LINE_W), .M(ZONE_W)) u_div_col (
    .clk(clk), .en(adv), .rem_i('0), .num_i(in_pixel_index), .div_i(zc_eff),
    .quo_o(col_q), .rem_o(col_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_W; i++) begin
        fr_r[i] <= '0;
      end
    end else if (adv) begin
      fr_r[0] <= '{vld: acc, cmd: in_command, waddr: in_tie_address,
                   wval: in_tie_value, wvld: in_tie_valid};
      for (int i = 1; i < LINE_W; i++) begin
        fr_r[i] <= fr_r[i-1];
      end
    end
  end

  // address and weight stages
  front_t             s1_r, s2_r, s3_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [LINE_W-1:0]  s1_col_r, s2_col_r;
  logic [ZONE_W-1:0]  s1_v_r, s1_u_r;
  logic [BASE_W-1:0]  s2_base_r;
  logic [WGT_W-1:0]   s2_w_r [4];
  logic [WGT_W-1:0]   s3_w_r [4];
  logic [WGT_W-1:0]   s4_w_r [4];
  logic [ZONE_W-1:0]  wa, wb;
  logic [CW-1:0]      a_full, d_full, c_full;
  logic [AW-1:0]      s3_a_r, s3_d_r;
  logic               s3_oob_r;

  assign wa     = za_eff - s1_v_r;
  assign wb     = zc_eff - s1_u_r;
  assign a_full = CW'(s2_base_r) + CW'(s2_col_r);
  assign d_full = a_full + CW'(tcol_r);
  assign c_full = d_full + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (adv) begin
      s1_r <= fr_r[LINE_W-1];
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row_r  <= ROW_W'(scan_q) + ROW_W'(row_q);
      s1_col_r  <= col_q;
      s1_v_r    <= row_rem;
      s1_u_r    <= col_rem;
      s2_base_r <= BASE_W'(s1_row_r) * BASE_W'(tcol_r);
      s2_col_r  <= s1_col_r;
      s2_w_r[0] <= WGT_W'(wa) * WGT_W'(wb);
      s2_w_r[1] <= WGT_W'(wa) * WGT_W'(s1_u_r);
      s2_w_r[2] <= WGT_W'(s1_v_r) * WGT_W'(s1_u_r);
      s2_w_r[3] <= WGT_W'(s1_v_r) * WGT_W'(wb);
      s3_a_r    <= a_full[AW-1:0];
      s3_d_r    <= d_full[AW-1:0];
      s3_oob_r  <= c_full >= CW'(TIE_DEPTH);
      s3_w_r    <= s2_w_r;
      s4_w_r    <= s3_w_r;
    end
  end

  // tie store: even and odd address banks, {valid, value}
  logic [VAL_W:0]  mem0 [BD];
  logic [VAL_W:0]  mem1 [BD];
  logic [BW-1:0]   ia0, ib0, ia1, ib1, wi;
  logic            we0, we1, wr_hit;
  logic [VAL_W:0]  wd;
  logic [VAL_W:0]  rd0_ab_r, rd1_ab_r, rd0_dc_r, rd1_dc_r;

  assign ia0    = BW'(({1'b0, s3_a_r} + (AW+1)'(1)) >> 1);
  assign ia1    = BW'(s3_a_r >> 1);
  assign ib0    = BW'(({1'b0, s3_d_r} + (AW+1)'(1)) >> 1);
  assign ib1    = BW'(s3_d_r >> 1);
  assign wr_hit = adv && s3_r.vld && (s3_r.cmd == CMD_WRITE)
                  && (CW'(s3_r.waddr) < CW'(TIE_DEPTH));
  assign wi     = clr_busy_r ? clr_idx_r : BW'(s3_r.waddr >> 1);
  assign we0    = clr_busy_r || (wr_hit && !s3_r.waddr[0]);
  assign we1    = clr_busy_r || (wr_hit && s3_r.waddr[0]);
  assign wd     = clr_busy_r ? '0 : {s3_r.wvld, s3_r.wval};

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wi] <= wd;
    end
    if (we1) begin
      mem1[wi] <= wd;
    end
    if (adv) begin
      rd0_ab_r <= mem0[ia0];
      rd1_ab_r <= mem1[ia1];
      rd0_dc_r <= mem0[ib0];
      rd1_dc_r <= mem1[ib1];
    end
  end

  // corner select, validity, products
  logic        s4_vld_r, s4_cmd_r, s4_oob_r, s4_pa_r, s4_pd_r;
  logic        s5_vld_r, s5_pix_r;
  status_t     s5_st_r;
  logic [VAL_W:0] cA, cB, cC, cD;
  status_t     st5;
  logic signed [PROD_W-1:0] s5_p_r [4];

  assign cA = s4_pa_r ? rd1_ab_r : rd0_ab_r;
  assign cB = s4_pa_r ? rd0_ab_r : rd1_ab_r;
  assign cD = s4_pd_r ? rd1_dc_r : rd0_dc_r;
  assign cC = s4_pd_r ? rd0_dc_r : rd1_dc_r;

  always_comb begin
    if (s4_oob_r) begin
      st5 = ST_RANGE;
    end else if (!(cA[VAL_W] && cB[VAL_W] && cC[VAL_W] && cD[VAL_W])) begin
      st5 = ST_INVALID;
    end else begin
      st5 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_r.vld;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmd_r <= s3_r.cmd;
      s4_oob_r <= s3_oob_r;
      s4_pa_r  <= s3_a_r[0];
      s4_pd_r  <= s3_d_r[0];
      s5_pix_r <= (s4_cmd_r == CMD_PIXEL);
      s5_st_r  <= (s4_cmd_r == CMD_PIXEL) ? st5 : ST_OK;
      s5_p_r[0] <= $signed(cA[VAL_W-1:0]) * $signed({1'b0, s4_w_r[0]});
      s5_p_r[1] <= $signed(cB[VAL_W-1:0]) * $signed({1'b0, s4_w_r[1]});
      s5_p_r[2] <= $signed(cC[VAL_W-1:0]) * $signed({1'b0, s4_w_r[2]});
      s5_p_r[3] <= $signed(cD[VAL_W-1:0]) * $signed({1'b0, s4_w_r[3]});
    end
  end

  // blend sum
  logic                    s6_vld_r, s6_pix_r;
  status_t                 s6_st_r;
  logic signed [SUM_W-1:0] s6_sum_r;
  logic [SUM_W-1:0]        mag;
  logic                    neg6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_pix_r <= s5_pix_r;
      s6_st_r  <= s5_st_r;
      s6_sum_r <= SUM_W'(s5_p_r[0]) + SUM_W'(s5_p_r[1])
                + SUM_W'(s5_p_r[2]) + SUM_W'(s5_p_r[3]);
    end
  end

  assign neg6 = s6_sum_r[SUM_W-1];
  assign mag  = neg6 ? SUM_W'(-s6_sum_r) : SUM_W'(s6_sum_r);

  // rounding divider
  logic [QUO_W-1:0] quo2;
  logic [DEN_W-1:0] rem2;
  back_t            fb_r [QUO_W];

  tpbi_div #(.N(QUO_W), .M(DEN_W)) u_div_norm (
    .clk(clk), .en(adv), .rem_i(mag[QUO_W+DEN_W-1:QUO_W]), .num_i(mag[QUO_W-1:0]),
    .div_i(den_r), .quo_o(quo2), .rem_o(rem2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) begin
        fb_r[i] <= '0;
      end
    end else if (adv) begin
      fb_r[0] <= '{vld: s6_vld_r, pix: s6_pix_r, status: s6_st_r, neg: neg6,
                   pos: !neg6 && (s6_sum_r != '0)};
      for (int i = 1; i < QUO_W; i++) begin
        fb_r[i] <= fb_r[i-1];
      end
    end
  end

  // round, wrap, saturate
  back_t                   fb;
  logic                    up, gt;
  logic [QUO_W:0]          qm;
  logic signed [WW-1:0]    qw, qs;
  logic signed [VAL_W-1:0] val_nxt;
  logic signed [VAL_W-1:0] out_value_r;
  status_t                 out_status_r;

  assign fb = fb_r[QUO_W-1];

  always_comb begin
    up = ({1'b0, rem2} + {1'b0, den_r >> 1}) >= {1'b0, den_r};
    qm = {1'b0, quo2} + (QUO_W+1)'(up);
    qw = $signed(WW'(qm));
    qs = fb.neg ? -qw : qw;
    gt = wrap_r && fb.pos
         && ((WW'(quo2) > K180) || ((WW'(quo2) == K180) && (rem2 != '0)));
    if (gt) begin
      qs = qs - $signed(K360);
    end
    if (qs > SAT_HI) begin
      qs = SAT_HI;
    end else if (qs < SAT_LO) begin
      qs = SAT_LO;
    end
    val_nxt = (fb.pix && fb.status == ST_OK) ? qs[VAL_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fb.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= val_nxt;
      out_status_r <= fb.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s3_r.vld && !s4_vld_r)
    else $error("transaction reached the tie store during the clearing pass");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_value == '0)
    else $error("nonzero value with error status");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the pipeline is stalled");

  a_clear_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> !out_valid && !fb.vld)
    else $error("result present at the end of the clearing pass");
`endif

endmodule

// ----- tb/tb_tie_point_bilinear_interpolator.sv -----
// Self-checking testbench for tie_point_bilinear_interpolator: random tie writes and
// pixel transactions over several geometry settings, checked against a built-in predictor.
// Depends on tpbi_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_tie_point_bilinear_interpolator
  import tpbi_pkg::*;
;

  localparam int DEPTH = 16384;
  localparam int FRAC = 20;
  localparam int DRAIN = 60;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
  } blend_t;

  class blend_scoreboard;
    logic signed [VAL_W-1:0] tie_val [DEPTH];
    bit                      tie_ok  [DEPTH];
    logic [LPS_W-1:0]        lps;
    logic [ZONE_W-1:0]       zalt;
    logic [ZONE_W-1:0]       zact;
    logic [TCOL_W-1:0]       tcols;
    bit                      wrap;
    blend_t                  pending[$];
    int                      errors;

    function new();
      foreach (tie_ok[i]) tie_ok[i] = 0;
      lps = LPS_RST;
      zalt = ZALT_RST;
      zact = ZACT_RST;
      tcols = TCOL_RST;
      wrap = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_LINES_PER_SCAN: lps = d[LPS_W-1:0];
        CFG_ZONE_ALT:       zalt = d[ZONE_W-1:0];
        CFG_ZONE_ACT:       zact = d[ZONE_W-1:0];
        CFG_TIE_COLUMNS:    tcols = d[TCOL_W-1:0];
        CFG_WRAP_LONGITUDE: wrap = d[0];
        default: ;
      endcase
    endfunction

    function void corners(longint ln, longint px, output longint addr[4]);
      longint l, za, zc, row0, col0;
      l = (lps == 0) ? 1 : lps;
      za = (zalt == 0) ? 1 : zalt;
      zc = (zact == 0) ? 1 : zact;
      row0 = ln / za + ln / l;
      col0 = px / zc;
      addr[0] = row0 * tcols + col0;
      addr[1] = row0 * tcols + col0 + 1;
      addr[2] = (row0 + 1) * tcols + col0 + 1;
      addr[3] = (row0 + 1) * tcols + col0;
    endfunction

    function void note_input(bit cmd, logic [ADDR_W-1:0] a, logic signed [VAL_W-1:0] val,
                             bit vld, logic [LINE_W-1:0] ln, logic [LINE_W-1:0] px);
      blend_t e;
      longint addr[4];
      longint za, zc, v, u, sum, den, mag, q;
      bit out_range, invalid;
      e.value = 0;
      e.status = ST_OK;
      if (cmd == CMD_WRITE) begin
        tie_val[a] = val;
        tie_ok[a] = vld;
      end else begin
        za = (zalt == 0) ? 1 : zalt;
        zc = (zact == 0) ? 1 : zact;
        v = ln % za;
        u = px % zc;
        corners(ln, px, addr);
        out_range = 0;
        invalid = 0;
        for (int k = 0; k < 4; k++) if (addr[k] >= DEPTH) out_range = 1;
        if (!out_range) for (int k = 0; k < 4; k++) if (!tie_ok[addr[k]]) invalid = 1;
        if (out_range) e.status = ST_RANGE;
        else if (invalid) e.status = ST_INVALID;
        else begin
          sum = (za - v) * (zc - u) * longint'(tie_val[addr[0]])
              + (za - v) * u * longint'(tie_val[addr[1]])
              + v * u * longint'(tie_val[addr[2]])
              + v * (zc - u) * longint'(tie_val[addr[3]]);
          den = za * zc;
          mag = (sum < 0) ? -sum : sum;
          q = (mag + den / 2) / den;
          if (sum < 0) q = -q;
          if (wrap && sum > (longint'(180) <<< FRAC) * den) q -= longint'(360) <<< FRAC;
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          e.value = q[31:0];
        end
      end
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(logic signed [VAL_W-1:0] value, logic [1:0] status);
      blend_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = pending.pop_front();
        if (status !== e.status) report("status", status, e.status);
        if (value !== e.value) report("value", value, e.value);
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_command;
  logic [ADDR_W-1:0]       in_tie_address;
  logic signed [VAL_W-1:0] in_tie_value;
  logic                    in_tie_valid;
  logic [LINE_W-1:0]       in_line_index;
  logic [LINE_W-1:0]       in_pixel_index;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_value;
  logic [1:0]              out_status;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  tie_point_bilinear_interpolator dut (.*);

  blend_scoreboard sb = new();
  bit     written [DEPTH];
  bit     calm;
  longint cycles = 0;
  int     out_stall = 0;

  function automatic int gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_tie();
    int r;
    r = $urandom_range(9);
    if (r < 4) return $urandom();
    if (r == 4) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return ($signed($urandom_range(720)) - 360) * (1 <<< FRAC) + $signed($urandom_range(1 << FRAC));
  endfunction

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check(out_value, out_status);

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if (!calm) out_stall = gap();
    end
  end

  task send(bit cmd, logic [ADDR_W-1:0] a, logic signed [VAL_W-1:0] val, bit vld,
            logic [LINE_W-1:0] ln, logic [LINE_W-1:0] px);
    int g;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_tie_address <= a;
    in_tie_value <= val;
    in_tie_valid <= vld;
    in_line_index <= ln;
    in_pixel_index <= px;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, a, val, vld, ln, px);
    @(negedge clk);
    g = calm ? 0 : gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task write_tie(logic [ADDR_W-1:0] a, logic signed [VAL_W-1:0] val, bit vld);
    written[a] = 1;
    send(CMD_WRITE, a, val, vld, LINE_W'($urandom()), LINE_W'($urandom()));
  endtask

  // every in-range corner gets written before the pixel is sent
  task pixel(logic [LINE_W-1:0] ln, logic [LINE_W-1:0] px);
    longint addr[4];
    sb.corners(ln, px, addr);
    for (int k = 0; k < 4; k++)
      if (addr[k] < DEPTH && !written[addr[k]])
        write_tie(ADDR_W'(addr[k]), rand_tie(), $urandom_range(19) != 0);
    send(CMD_PIXEL, ADDR_W'($urandom()), $urandom(), 1'($urandom()), ln, px);
  endtask

  task settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task configure(logic [CFG_W-1:0] lps, logic [CFG_W-1:0] za, logic [CFG_W-1:0] zc,
                 logic [CFG_W-1:0] tc, logic [CFG_W-1:0] wr);
    logic [CFG_W-1:0] vals[5];
    vals = '{lps, za, zc, tc, wr};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      sb.set_reg(i[CFG_IDX_W-1:0], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task random_phase(int count);
    longint za, zc, tc, rows, lmax, pmax;
    za = (sb.zalt == 0) ? 1 : sb.zalt;
    zc = (sb.zact == 0) ? 1 : sb.zact;
    tc = (sb.tcols == 0) ? 1 : sb.tcols;
    rows = DEPTH / tc;
    lmax = rows * za + za;
    pmax = (tc + 1) * zc;
    if (lmax > DEPTH - 1) lmax = DEPTH - 1;
    if (pmax > DEPTH - 1) pmax = DEPTH - 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 10)
        write_tie(ADDR_W'($urandom()), rand_tie(), 1'($urandom_range(1)));
      else if ($urandom_range(99) < 15)
        pixel(LINE_W'($urandom()), LINE_W'($urandom()));
      else
        pixel(LINE_W'($urandom_range(int'(lmax))), LINE_W'($urandom_range(int'(pmax))));
    end
  endtask

  initial begin
    foreach (written[i]) written[i] = 0;
    calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_WRITE;
    in_tie_address = '0;
    in_tie_value = '0;
    in_tie_valid = 1'b0;
    in_line_index = '0;
    in_pixel_index = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, invalid corner, out-of-store corner, defaults geometry
    write_tie(0, 32'sh7fffffff, 1);
    write_tie(1, 32'sh80000000, 1);
    write_tie(394, 0, 1);
    write_tie(395, -1, 1);
    pixel(0, 0);
    pixel(9, 7);
    pixel(5, 4);
    write_tie(DEPTH - 1, 32'sh80000000, 1);
    write_tie(2, 32'sh00100000, 0);
    pixel(0, 8);
    pixel(16383, 16383);
    pixel(0, 16383);
    settle();

    configure(1, 1, 1, 2, 1);
    write_tie(4, 200 <<< FRAC, 1);
    pixel(0, 0);
    random_phase(40);
    settle();

    configure(4095, 1023, 1023, 4095, 0);
    pixel(1022, 1022);
    random_phase(20);
    settle();

    configure(0, 0, 0, 0, 1);
    random_phase(30);
    settle();

    configure(30, 10, 8, 394, 1);
    calm = 1;
    random_phase(45);
    calm = 0;
    settle();

    for (int p = 0; p < 5; p++) begin
      configure(CFG_W'($urandom_range(4095)),
                CFG_W'($urandom_range(1023) % ($urandom_range(1) ? 1024 : 17)),
                CFG_W'($urandom_range(1023) % ($urandom_range(1) ? 1024 : 17)),
                CFG_W'($urandom_range(4095) % ($urandom_range(1) ? 4096 : 600)),
                CFG_W'($urandom_range(1)));
      random_phase(40);
      settle();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tpbi_pkg.sv
rtl/core/tpbi_div.sv
rtl/core/tie_point_bilinear_interpolator.sv
tb/tb_tie_point_bilinear_interpolator.sv
